// ===== hdl/ppfc_pkg.sv =====
// Shared constants for the Paeth pixel filter codec.
// Used by the core and the byte lane; depends on nothing.
`timescale 1ns / 1ps

package ppfc_pkg;

   // Pixel layout: eight bytes per word
   localparam int BYTES   = 8;
   localparam int BYTE_W  = 8;
   localparam int PIXEL_W = BYTES * BYTE_W;

   // Line store geometry
   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Configuration registers
   localparam int WIDTH_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = WIDTH_W;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 2'd1;

   // Counter width wide enough for column + 1 and the line width
   localparam int CNT_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

endpackage

// ===== hdl/paeth_pixel_filter_codec_core.sv =====
// Paeth pixel filter codec top level: control, context registers, result register.
// Depends on ppfc_pkg, ppfc_line_ram and ppfc_byte_lane.
`timescale 1ns / 1ps

// One 8-byte pixel word per cycle in raster order, one result word per pixel.
// Throughput is one word per clock with no bubbles while rsp_ready stays high;
// an accepted word passes the stage 1 register, then the result register that
// drives rsp_valid. The 4096 x 64 previous-row store is read at accept, with a bypass when the
// word ahead writes the same column (one-pixel rows). csr_we with csr_index 0
// sets line_width (0 acts as 1, values above 4096 act as 4096) and index 1 sets
// decode_mode (0 encode, 1 decode). Write registers only while the block is idle.
// The line store has no reset; only the first row is defined until each column
// is written, so raising line_width after the first row gives undefined "above".
module paeth_pixel_filter_codec_core (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [ppfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppfc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // pixel in
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte_0,
   input  logic [7:0]                       req_in_byte_1,
   input  logic [7:0]                       req_in_byte_2,
   input  logic [7:0]                       req_in_byte_3,
   input  logic [7:0]                       req_in_byte_4,
   input  logic [7:0]                       req_in_byte_5,
   input  logic [7:0]                       req_in_byte_6,
   input  logic [7:0]                       req_in_byte_7,
   // result out
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte_0,
   output logic [7:0]                       rsp_out_byte_1,
   output logic [7:0]                       rsp_out_byte_2,
   output logic [7:0]                       rsp_out_byte_3,
   output logic [7:0]                       rsp_out_byte_4,
   output logic [7:0]                       rsp_out_byte_5,
   output logic [7:0]                       rsp_out_byte_6,
   output logic [7:0]                       rsp_out_byte_7
);

   localparam int PW = ppfc_pkg::PIXEL_W;
   localparam int BW = ppfc_pkg::BYTE_W;
   localparam int NB = ppfc_pkg::BYTES;
   localparam int CW = ppfc_pkg::COL_W;
   localparam int NW = ppfc_pkg::CNT_W;
   localparam int WW = ppfc_pkg::WIDTH_W;

   // configuration registers
   logic [WW-1:0] line_width_ff;
   logic          decode_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= WW'(1);
         decode_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            ppfc_pkg::CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata[WW-1:0];
            ppfc_pkg::CSR_DECODE_MODE: decode_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic s1_go, accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // column tracking at accept time
   logic [CW-1:0] column_ff, column_in;
   logic          first_row_ff, first_row_in;
   logic [NW-1:0] w_eff, col_ext, col_use, col_inc;
   logic          wrap, last;

   always_comb begin
      if (line_width_ff == '0) begin
         w_eff = NW'(1);
      end else if (NW'(line_width_ff) > NW'(ppfc_pkg::MAX_WIDTH)) begin
         w_eff = NW'(ppfc_pkg::MAX_WIDTH);
      end else begin
         w_eff = NW'(line_width_ff);
      end
      col_ext = NW'(column_ff);
      wrap    = col_ext >= w_eff;
      col_use = wrap ? '0 : col_ext;
      col_inc = col_use + NW'(1);
      last    = col_inc >= w_eff;
      column_in    = last ? '0 : col_inc[CW-1:0];
      first_row_in = last ? 1'b0 : first_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         column_ff    <= column_in;
         first_row_ff <= first_row_in;
      end
   end

   // stage 1 word register
   logic [PW-1:0] s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_first_ff, s1_zero_ff, s1_last_ff;
   logic [PW-1:0] req_pixel;

   assign req_pixel = {req_in_byte_7, req_in_byte_6, req_in_byte_5, req_in_byte_4,
                       req_in_byte_3, req_in_byte_2, req_in_byte_1, req_in_byte_0};

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_use[CW-1:0];
         s1_first_ff <= first_row_ff;
         s1_zero_ff  <= wrap;
         s1_last_ff  <= last;
      end
   end

   // line store with same-column bypass
   logic [PW-1:0] ram_rd_data;
   logic [PW-1:0] raw_pixel;
   logic          byp_ff;
   logic [PW-1:0] byp_data_ff;

   ppfc_line_ram #(
      .DEPTH  (ppfc_pkg::MAX_WIDTH),
      .DATA_W (PW),
      .ADDR_W (CW)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_use[CW-1:0]),
      .rd_data (ram_rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (raw_pixel)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_ff      <= s1_go && (s1_col_ff == col_use[CW-1:0]);
         byp_data_ff <= raw_pixel;
      end
   end

   // context for the word in stage 1
   logic [PW-1:0] left_ff, upper_left_ff;
   logic [PW-1:0] ctx_left, ctx_above, ctx_ul;

   always_comb begin
      ctx_left  = s1_zero_ff ? '0 : left_ff;
      ctx_above = s1_first_ff ? '0 : (byp_ff ? byp_data_ff : ram_rd_data);
      ctx_ul    = (s1_zero_ff || s1_first_ff) ? '0 : upper_left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else if (s1_go) begin
         left_ff       <= s1_last_ff ? '0 : raw_pixel;
         upper_left_ff <= s1_last_ff ? '0 : ctx_above;
      end
   end

   // eight Paeth lanes
   logic [PW-1:0] res_pixel;

   for (genvar k = 0; k < NB; k++) begin : g_lane
      ppfc_byte_lane u_lane (
         .x      (s1_pixel_ff[k*BW +: BW]),
         .a      (ctx_left[k*BW +: BW]),
         .b      (ctx_above[k*BW +: BW]),
         .c      (ctx_ul[k*BW +: BW]),
         .decode (decode_mode_ff),
         .res    (res_pixel[k*BW +: BW]),
         .raw    (raw_pixel[k*BW +: BW])
      );
   end

   // result register
   logic [PW-1:0] rsp_pixel_ff;

   always_comb begin
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_pixel_ff <= res_pixel;
      end
   end

   assign rsp_out_byte_0 = rsp_pixel_ff[0*BW +: BW];
   assign rsp_out_byte_1 = rsp_pixel_ff[1*BW +: BW];
   assign rsp_out_byte_2 = rsp_pixel_ff[2*BW +: BW];
   assign rsp_out_byte_3 = rsp_pixel_ff[3*BW +: BW];
   assign rsp_out_byte_4 = rsp_pixel_ff[4*BW +: BW];
   assign rsp_out_byte_5 = rsp_pixel_ff[5*BW +: BW];
   assign rsp_out_byte_6 = rsp_pixel_ff[6*BW +: BW];
   assign rsp_out_byte_7 = rsp_pixel_ff[7*BW +: BW];

endmodule

// ===== hdl/ppfc_line_ram.sv =====
// Single-port-write, single-port-read line store with registered read data.
// Holds the raw pixels of the previous row; no dependencies.
`timescale 1ns / 1ps

module ppfc_line_ram #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 64,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ppfc_byte_lane.sv =====
// One byte lane: Paeth prediction plus encode/decode arithmetic.
// Uses ppfc_pkg for the byte width.
`timescale 1ns / 1ps

module ppfc_byte_lane (
   input  logic [ppfc_pkg::BYTE_W-1:0] x,
   input  logic [ppfc_pkg::BYTE_W-1:0] a,
   input  logic [ppfc_pkg::BYTE_W-1:0] b,
   input  logic [ppfc_pkg::BYTE_W-1:0] c,
   input  logic                        decode,
   output logic [ppfc_pkg::BYTE_W-1:0] res,
   output logic [ppfc_pkg::BYTE_W-1:0] raw
);

   logic signed [ppfc_pkg::BYTE_W+1:0] sa, sb, sc, p, ea, eb, ec;
   logic        [ppfc_pkg::BYTE_W:0]   da, db, dc;
   logic        [ppfc_pkg::BYTE_W-1:0] pred;

   // p = a + b - c, distances to each neighbor
   always_comb begin
      sa = $signed({2'b00, a});
      sb = $signed({2'b00, b});
      sc = $signed({2'b00, c});
      p  = sa + sb - sc;
      ea = p - sa;
      eb = p - sb;
      ec = p - sc;
      da = ea[ppfc_pkg::BYTE_W+1] ? 9'(-ea) : 9'(ea);
      db = eb[ppfc_pkg::BYTE_W+1] ? 9'(-eb) : 9'(eb);
      dc = ec[ppfc_pkg::BYTE_W+1] ? 9'(-ec) : 9'(ec);
   end

   // tie break order: left, above, upper-left
   always_comb begin
      priority if (da <= db && da <= dc) begin
         pred = a;
      end else if (db <= dc) begin
         pred = b;
      end else begin
         pred = c;
      end
   end

   // mod 256 arithmetic; raw is the unfiltered byte kept as context
   always_comb begin
      if (decode) begin
         res = x + pred;
         raw = res;
      end else begin
         res = x - pred;
         raw = x;
      end
   end

endmodule
